FILE: rtl/core/dmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types, constants and lane decode for the downmix/resample block.
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int MaxChannels = 8;

    localparam logic [17:0] OUT_RATE   = 18'd48000;
    localparam logic [17:0] RATE_MIN   = 18'd8000;
    localparam logic [17:0] RATE_MAX   = 18'd192000;
    localparam logic [2:0]  RESULT_CAP = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_IDX_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_IDX_RATE     = 2'd2;

    typedef enum logic [1:0] {
        FMT_FLOAT32 = 2'd0,
        FMT_PCM16   = 2'd1,
        FMT_PCM32   = 2'd2,
        FMT_NONE    = 2'd3
    } dmx_fmt_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SUM,
        F_CLAMP,
        F_SCALE,
        F_DIV,
        F_PUSH
    } dmx_fstate_t;

    typedef struct packed {
        logic [31:0] sample_0;
        logic [31:0] sample_1;
        logic [31:0] sample_2;
        logic [31:0] sample_3;
        logic [31:0] sample_4;
        logic [31:0] sample_5;
        logic [31:0] sample_6;
        logic [31:0] sample_7;
        logic        final_frame;
    } dmx_in_t;

    typedef struct packed {
        logic signed [15:0] mono_sample;
        logic               run_last;
        logic               buffer_last;
    } dmx_out_t;

    typedef struct packed {
        dmx_fmt_t    fmt;
        logic [3:0]  channels;
        logic [17:0] rate;
    } dmx_cfg_t;

    // one classified frame: its mono value and how many outputs it makes
    typedef struct packed {
        logic signed [15:0] sample;
        logic [2:0]         count;
        logic               final_frame;
    } dmx_entry_t;

    // raw lane bits to Q31 in 34 bits; float truncates and saturates at +-2
    function automatic logic signed [33:0] lane_q31(input logic [31:0] raw,
                                                    input dmx_fmt_t fmt);
        logic [7:0]         e;
        logic [7:0]         sh;
        logic [32:0]        full;
        logic [32:0]        mag;
        logic signed [33:0] r;
        e    = raw[30:23];
        full = {9'b0, 1'b1, raw[22:0]};
        mag  = '0;
        sh   = '0;
        r    = '0;
        case (fmt)
            FMT_FLOAT32:
            begin
                if (e == 8'hFF && raw[22:0] != 23'd0) begin
                    mag = '0;                       // NaN reads zero
                end else if (e >= 8'd128) begin
                    mag = 33'h1_0000_0000;          // infinity or |x| >= 2
                end else if (e == 8'd0) begin
                    mag = '0;                       // zero and subnormals
                end else if (e >= 8'd119) begin
                    mag = full << (e - 8'd119);
                end else begin
                    sh  = 8'd119 - e;
                    mag = (sh >= 8'd24) ? 33'd0 : (full >> sh);
                end
                r = raw[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            FMT_PCM16: r = {{2{raw[15]}}, raw[15:0], 16'h0000};
            FMT_PCM32: r = {{2{raw[31]}}, raw};
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/dmx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_queue
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module dmx_queue import dmx_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dmx_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output dmx_entry_t head,
    output logic       empty
);

    dmx_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/dmx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_front
// Accepts frames, computes the mono value and the output count per frame.
// ----------------------------------------------------------------------------
module dmx_front import dmx_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dmx_cfg_t   cfg,
    input  logic       frame_valid,
    output logic       frame_stall,
    input  dmx_in_t    frame,
    output logic       push,
    output dmx_entry_t push_entry,
    input  logic       q_full
);

    dmx_fstate_t        state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [17:0]        phase_reg, phase_next;
    logic [18:0]        acc_reg, acc_next;
    logic [2:0]         cnt_reg, cnt_next;

    logic signed [33:0] lane_reg [MaxChannels];
    logic signed [36:0] sum_reg, sum_next;
    logic               neg_reg, neg_next;
    logic [34:0]        mag_reg, mag_next;
    logic [17:0]        quo_reg, quo_next;
    logic [3:0]         rem_reg, rem_next;
    logic [3:0]         chans_reg, chans_next;
    logic [17:0]        rate_reg, rate_next;
    logic               final_reg, final_next;

    logic               accept;
    logic               cont;
    logic [19:0]        acc_plus;
    logic [35:0]        abs_sum;
    logic [34:0]        limit;
    logic [49:0]        scaled;
    logic [4:0]         trial;
    logic [15:0]        q16;

    logic [31:0]        raw [MaxChannels];

    assign raw[0] = frame.sample_0;
    assign raw[1] = frame.sample_1;
    assign raw[2] = frame.sample_2;
    assign raw[3] = frame.sample_3;
    assign raw[4] = frame.sample_4;
    assign raw[5] = frame.sample_5;
    assign raw[6] = frame.sample_6;
    assign raw[7] = frame.sample_7;

    assign frame_stall = (state_reg != F_IDLE);
    assign accept      = frame_valid && (state_reg == F_IDLE);

    // one step of the phase walk per working cycle
    assign acc_plus = {1'b0, acc_reg} + {2'b00, rate_reg};
    assign cont     = (cnt_reg < RESULT_CAP) &&
                      (final_reg ? (acc_plus <= {2'b00, OUT_RATE})
                                 : (acc_reg < {1'b0, OUT_RATE}));

    assign abs_sum = sum_reg[36] ? 36'(-sum_reg) : 36'(sum_reg);
    assign limit   = {chans_reg, 31'd0};
    assign scaled  = {mag_reg, 15'd0} - {15'd0, mag_reg};   // mag * 32767
    assign q16     = quo_reg[15:0];

    assign push_entry.sample      = neg_reg ? $signed(~q16 + 16'd1) : $signed(q16);
    assign push_entry.count       = cnt_reg;
    assign push_entry.final_frame = final_reg;
    assign push = (state_reg == F_PUSH) && (cnt_reg != 3'd0) && !q_full;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        chans_next = chans_reg;
        rate_next  = rate_reg;
        final_next = final_reg;
        trial      = '0;

        if (state_reg != F_IDLE && state_reg != F_PUSH && cont) begin
            cnt_next = cnt_reg + 3'd1;
            acc_next = acc_plus[18:0];
        end

        case (state_reg)
            F_IDLE:
            begin
                if (accept) begin
                    state_next = F_SUM;
                    acc_next   = {1'b0, phase_reg};
                    cnt_next   = 3'd0;
                    final_next = frame.final_frame;
                    if (cfg.channels == 4'd0) begin
                        chans_next = 4'd1;
                    end else if (cfg.channels > 4'(MaxChannels)) begin
                        chans_next = 4'(MaxChannels);
                    end else begin
                        chans_next = cfg.channels;
                    end
                    if (cfg.rate < RATE_MIN) begin
                        rate_next = RATE_MIN;
                    end else if (cfg.rate > RATE_MAX) begin
                        rate_next = RATE_MAX;
                    end else begin
                        rate_next = cfg.rate;
                    end
                end
            end
            F_SUM:
            begin
                sum_next = '0;
                for (int i = 0; i < MaxChannels; i++) begin
                    if (4'(i) < chans_reg) begin
                        sum_next = sum_next + 37'(lane_reg[i]);
                    end
                end
                state_next = F_CLAMP;
            end
            F_CLAMP:
            begin
                neg_next   = sum_reg[36];
                mag_next   = (abs_sum > {1'b0, limit}) ? limit : abs_sum[34:0];
                state_next = F_SCALE;
            end
            F_SCALE:
            begin
                quo_next   = scaled[48:31];
                rem_next   = 4'd0;
                step_next  = 2'd0;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                // six restoring-division bits per cycle, divisor is the channel count
                for (int j = 0; j < 6; j++) begin
                    trial    = {rem_next, quo_next[17]};
                    quo_next = {quo_next[16:0], 1'b0};
                    if (trial >= {1'b0, chans_reg}) begin
                        trial       = trial - {1'b0, chans_reg};
                        quo_next[0] = 1'b1;
                    end
                    rem_next = trial[3:0];
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (cnt_reg == 3'd0 || !q_full) begin
                    state_next = F_IDLE;
                    if (final_reg) begin
                        phase_next = 18'd0;
                    end else if (acc_reg >= {1'b0, OUT_RATE}) begin
                        phase_next = 18'(acc_reg - {1'b0, OUT_RATE});
                    end else begin
                        phase_next = 18'd0;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
            phase_reg <= 18'd0;
            cnt_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        chans_reg <= chans_next;
        rate_reg  <= rate_next;
        final_reg <= final_next;
        if (accept) begin
            for (int i = 0; i < MaxChannels; i++) begin
                lane_reg[i] <= lane_q31(raw[i], cfg.fmt);
            end
        end
    end

endmodule

FILE: rtl/core/dmx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_back
// Replays each queued frame as its run of mono items into the output register.
// ----------------------------------------------------------------------------
module dmx_back import dmx_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dmx_entry_t head,
    input  logic       q_empty,
    output logic       pop,
    output logic       mono_valid,
    input  logic       mono_stall,
    output dmx_out_t   mono
);

    logic [2:0] k_reg, k_next;
    logic       valid_reg, valid_next;
    dmx_out_t   out_reg, out_next;
    logic       load;
    logic       last;

    assign load       = !q_empty && (!valid_reg || !mono_stall);
    assign last       = (k_reg == 3'(head.count - 3'd1));
    assign pop        = load && last;
    assign mono_valid = valid_reg;
    assign mono       = out_reg;

    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (load) begin
            valid_next           = 1'b1;
            out_next.mono_sample = head.sample;
            out_next.run_last    = last;
            out_next.buffer_last = last && head.final_frame;
            k_next               = last ? 3'd0 : (k_reg + 3'd1);
        end else if (!mono_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg     <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

FILE: rtl/core/downmix_resample_to_mono16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downmix_resample_to_mono16
// Multichannel frame to 16-bit mono at 48 kHz, nearest-lower-frame resampling.
// ----------------------------------------------------------------------------
// Each accepted frame is averaged over channel_count lanes (float32, pcm16 or
// pcm32), clamped to [-1,1] and scaled to trunc(mean*32767). A phase
// accumulator decides how many 48 kHz output items (zero to six) the frame
// makes; a frame marked final_frame only makes those that fit inside the
// buffer and then clears the phase. Per frame the front runs an accept
// state, working states (lane sum, clamp, scale, then a divider by the
// channel count that resolves six quotient bits a cycle, while the phase
// walk takes one output step per cycle) and a handoff into a two-frame
// queue, which waits while the queue is full. The back drains the queue at
// one output item per cycle, unless mono_stall holds it, through a
// registered output, while the front already works on the next frame.
// Configuration writes are always ready and take effect on the next
// accepted frame; write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module downmix_resample_to_mono16 import dmx_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // frame input channel
    input  logic        frame_valid,
    output logic        frame_stall,
    input  dmx_in_t     frame,
    // mono output channel
    output logic        mono_valid,
    input  logic        mono_stall,
    output dmx_out_t    mono,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    // configuration registers
    dmx_fmt_t    fmt_reg, fmt_next;
    logic [3:0]  chans_reg, chans_next;
    logic [17:0] rate_reg, rate_next;
    dmx_cfg_t    cfg;

    // queue hookup
    logic        push;
    dmx_entry_t  push_entry;
    logic        q_full;
    logic        pop;
    dmx_entry_t  head;
    logic        q_empty;

    assign cfg_ready    = 1'b1;
    assign cfg.fmt      = fmt_reg;
    assign cfg.channels = chans_reg;
    assign cfg.rate     = rate_reg;

    // writes to an index past the register list are dropped
    always_comb
    begin
        fmt_next   = fmt_reg;
        chans_next = chans_reg;
        rate_next  = rate_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_FORMAT:   fmt_next   = dmx_fmt_t'(cfg_data[1:0]);
                CFG_IDX_CHANNELS: chans_next = cfg_data[3:0];
                CFG_IDX_RATE:     rate_next  = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg   <= FMT_PCM16;
            chans_reg <= 4'd2;
            rate_reg  <= OUT_RATE;
        end else begin
            fmt_reg   <= fmt_next;
            chans_reg <= chans_next;
            rate_reg  <= rate_next;
        end
    end

    // front: accept, downmix, scale, count outputs
    dmx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .push        (push),
        .push_entry  (push_entry),
        .q_full      (q_full)
    );

    // queue decouples the frame rate from the output rate
    dmx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    // back: one mono item per cycle while the output is not stalled
    dmx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .mono_valid (mono_valid),
        .mono_stall (mono_stall),
        .mono       (mono)
    );

endmodule

FILE: rtl/core/dmx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_checker
// Port-level checks for the downmix/resample block, bound to the top level.
// ----------------------------------------------------------------------------
module dmx_checker import dmx_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     frame_valid,
    input logic     frame_stall,
    input logic     mono_valid,
    input logic     mono_stall,
    input dmx_out_t mono
);

    // end of buffer is always the end of a frame's run
    a_buffer_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        mono_valid && mono.buffer_last |-> mono.run_last)
        else $error("buffer_last without run_last");

    // scaling never reaches the most negative code
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        mono_valid |-> (mono.mono_sample != 16'sh8000))
        else $error("mono sample out of range");

    // front is busy the cycle after it takes a frame
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("front took frames back to back");

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mono_valid && mono_stall |=> mono_valid && $stable(mono))
        else $error("stalled output item changed");

endmodule

bind downmix_resample_to_mono16 dmx_checker u_dmx_checker (.*);
